/* design/btx_pkg.sv */
// Shared constants, command codes and status codes of the binary trie xor query block.
package btx_pkg;

  localparam int unsigned KeyBitsDef   = 31;
  localparam int unsigned NodeCountDef = 4096;
  localparam int unsigned CountBitsDef = 16;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned KeyW    = 31;
  localparam int unsigned ResultW = 31;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_MAX_XOR = 2'd2,
    CMD_MIN_XOR = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

endpackage

/* design/btx_node_ram.sv */
// Node pool memory with one write port and two registered read ports.
module btx_node_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 56,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_a_i,
  output logic [WIDTH-1:0]  rd_data_a_o,
  input  logic [ADDR_W-1:0] rd_addr_b_i,
  output logic [WIDTH-1:0]  rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

/* design/binary_trie_xor_query.sv */
// Top level of the binary trie that stores a multiset of keys and answers xor queries.
//
// Usage: one command enters per transfer on the input channel (in_valid_i,
// in_stall_o, command_i, key_i) and exactly one result leaves per command on
// the output channel (out_valid_o, out_stall_i, xor_result_o, status_o).
// Commands are insert, delete, max-xor query and min-xor query.
// The block works on one command at a time and walks the trie one level per
// cycle, since every level needs one read of the node pool memory and, for
// updates, one write back of the same node. A delete first checks the whole
// path and then walks it again to decrement the counts. A refused insert and
// a query on an empty set finish without walking the trie, and a delete of an
// absent key as soon as the missing link or leaf is found.
// A query reads both children of a node in the same cycle, one on each
// memory read port, to see which of them still holds keys.
// Reset empties the set at once: the root node reads as empty until it is
// first written, and no clearing pass is needed.
// A finished result waits in the output register while the receiver stalls;
// the next command is taken as soon as the result has moved there.
module binary_trie_xor_query
  import btx_pkg::*;
#(
  parameter int unsigned KEY_BITS   = KeyBitsDef,
  parameter int unsigned NODE_COUNT = NodeCountDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [KeyW-1:0]    key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ResultW-1:0] xor_result_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned NODE_BITS = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W    = NODE_BITS + 1;
  localparam int unsigned LVL_W     = $clog2(KEY_BITS + 1);
  localparam int unsigned WIDE_W    = (KEY_BITS > ResultW) ? KEY_BITS : ResultW;
  localparam int unsigned MULT_LO   = 0;
  localparam int unsigned PASS_LO   = COUNT_BITS;
  localparam int unsigned LINK0_LO  = 2 * COUNT_BITS;
  localparam int unsigned LINK1_LO  = 2 * COUNT_BITS + NODE_BITS;
  localparam int unsigned ENTRY_W   = 2 * COUNT_BITS + 2 * NODE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_QROOT = 3'd2;
  localparam logic [2:0] S_QWALK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CmdW-1:0]        cmd_q, cmd_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [KEY_BITS-1:0]    key_sh_q, key_sh_d;
  logic [LVL_W-1:0]       level_q, level_d;
  logic [NODE_BITS-1:0]   node_q, node_d;
  logic                   fresh_q, fresh_d;
  logic                   pass2_q, pass2_d;
  logic [2*NODE_BITS-1:0] links_q, links_d;
  logic [WIDE_W-1:0]      acc_q, acc_d;
  logic [StatusW-1:0]     res_stat_q, res_stat_d;
  logic [FREE_W-1:0]      next_free_q, next_free_d;
  logic                   root_valid_q, root_valid_d;
  logic                   a_zero_q;
  logic                   out_valid_q, out_valid_d;
  logic [ResultW-1:0]     xor_q, xor_d;
  logic [StatusW-1:0]     status_q, status_d;

  logic                   wr_en;
  logic [NODE_BITS-1:0]   wr_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [NODE_BITS-1:0]   rd_addr_a, rd_addr_b;
  logic [ENTRY_W-1:0]     rd_data_a, rd_data_b;

  logic [ENTRY_W-1:0]     entry_a;
  logic [COUNT_BITS-1:0]  cur_pass, cur_mult;
  logic [NODE_BITS-1:0]   cur_link0, cur_link1, link_b, new_link;
  logic                   bit_k, at_leaf, pool_low, count_full;
  logic [FREE_W-1:0]      free_nodes;
  logic [WIDE_W-1:0]      key_wide;
  logic [KEY_BITS-1:0]    key_in;
  logic                   want_max, pref, live0, live1, take;
  logic [NODE_BITS-1:0]   q_link0, q_link1, q_next;
  logic [ENTRY_W-1:0]     child_entry;

  btx_node_ram #(
    .DEPTH(NODE_COUNT),
    .WIDTH(ENTRY_W)
  ) u_node_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_addr_a_i(rd_addr_a),
    .rd_data_a_o(rd_data_a),
    .rd_addr_b_i(rd_addr_b),
    .rd_data_b_o(rd_data_b)
  );

  // A freshly allocated node and a root that was never written both read as empty.
  assign entry_a    = (fresh_q || (a_zero_q && !root_valid_q)) ? '0 : rd_data_a;
  assign cur_pass   = entry_a[PASS_LO +: COUNT_BITS];
  assign cur_mult   = entry_a[MULT_LO +: COUNT_BITS];
  assign cur_link0  = entry_a[LINK0_LO +: NODE_BITS];
  assign cur_link1  = entry_a[LINK1_LO +: NODE_BITS];
  assign bit_k      = key_sh_q[KEY_BITS-1];
  assign link_b     = bit_k ? cur_link1 : cur_link0;
  assign new_link   = (link_b == '0) ? next_free_q[NODE_BITS-1:0] : link_b;
  assign at_leaf    = (level_q == LVL_W'(KEY_BITS));
  assign free_nodes = FREE_W'(NODE_COUNT) - next_free_q;
  assign pool_low   = (free_nodes < FREE_W'(KEY_BITS));
  assign count_full = &cur_pass;

  assign key_wide = WIDE_W'(key_i);
  assign key_in   = key_wide[KEY_BITS-1:0];

  assign want_max    = (cmd_q == CMD_MAX_XOR);
  assign pref        = bit_k ^ want_max;
  assign q_link0     = links_q[NODE_BITS-1:0];
  assign q_link1     = links_q[2*NODE_BITS-1:NODE_BITS];
  assign live0       = (q_link0 != '0) && (rd_data_a[PASS_LO +: COUNT_BITS] != '0);
  assign live1       = (q_link1 != '0) && (rd_data_b[PASS_LO +: COUNT_BITS] != '0);
  assign take        = (pref ? live1 : live0) ? pref : ~pref;
  assign q_next      = take ? q_link1 : q_link0;
  assign child_entry = take ? rd_data_b : rd_data_a;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    key_sh_d     = key_sh_q;
    level_d      = level_q;
    node_d       = node_q;
    fresh_d      = fresh_q;
    pass2_d      = pass2_q;
    links_d      = links_q;
    acc_d        = acc_q;
    res_stat_d   = res_stat_q;
    next_free_d  = next_free_q;
    xor_d        = xor_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    wr_en        = 1'b0;
    wr_addr      = node_q;
    wr_data      = entry_a;
    rd_addr_a    = '0;
    rd_addr_b    = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = command_i;
          key_d      = key_in;
          key_sh_d   = key_in;
          level_d    = '0;
          node_d     = '0;
          fresh_d    = 1'b0;
          pass2_d    = 1'b0;
          acc_d      = '0;
          res_stat_d = ST_OK;
          if (command_i == CMD_INSERT || command_i == CMD_DELETE) begin
            state_d = S_WALK;
          end else begin
            state_d = S_QROOT;
          end
        end
      end
      S_WALK: begin
        if (cmd_q == CMD_INSERT) begin
          if (level_q == '0 && (pool_low || count_full)) begin
            res_stat_d = ST_FULL;
            state_d    = S_DONE;
          end else begin
            wr_en = 1'b1;
            wr_data[PASS_LO +: COUNT_BITS] = cur_pass + COUNT_BITS'(1);
            if (at_leaf) begin
              wr_data[MULT_LO +: COUNT_BITS] = cur_mult + COUNT_BITS'(1);
              state_d = S_DONE;
            end else begin
              if (bit_k) begin
                wr_data[LINK1_LO +: NODE_BITS] = new_link;
              end else begin
                wr_data[LINK0_LO +: NODE_BITS] = new_link;
              end
              if (link_b == '0) begin
                next_free_d = next_free_q + FREE_W'(1);
              end
              fresh_d   = (link_b == '0);
              node_d    = new_link;
              rd_addr_a = new_link;
              level_d   = level_q + LVL_W'(1);
              key_sh_d  = key_sh_q << 1;
            end
          end
        end else if (!pass2_q) begin
          if (at_leaf) begin
            if (cur_mult == '0) begin
              res_stat_d = ST_ABSENT;
              state_d    = S_DONE;
            end else begin
              pass2_d  = 1'b1;
              node_d   = '0;
              level_d  = '0;
              key_sh_d = key_q;
            end
          end else if (link_b == '0) begin
            res_stat_d = ST_ABSENT;
            state_d    = S_DONE;
          end else begin
            node_d    = link_b;
            rd_addr_a = link_b;
            level_d   = level_q + LVL_W'(1);
            key_sh_d  = key_sh_q << 1;
          end
        end else begin
          wr_en = 1'b1;
          wr_data[PASS_LO +: COUNT_BITS] = cur_pass - COUNT_BITS'(1);
          if (at_leaf) begin
            wr_data[MULT_LO +: COUNT_BITS] = cur_mult - COUNT_BITS'(1);
            state_d = S_DONE;
          end else begin
            node_d    = link_b;
            rd_addr_a = link_b;
            level_d   = level_q + LVL_W'(1);
            key_sh_d  = key_sh_q << 1;
          end
        end
      end
      S_QROOT: begin
        if (cur_pass == '0) begin
          res_stat_d = ST_EMPTY;
          state_d    = S_DONE;
        end else begin
          links_d   = {cur_link1, cur_link0};
          rd_addr_a = cur_link0;
          rd_addr_b = cur_link1;
          state_d   = S_QWALK;
        end
      end
      S_QWALK: begin
        acc_d = {acc_q[WIDE_W-2:0], take ^ bit_k};
        if (q_next == '0 || level_q == LVL_W'(KEY_BITS - 1)) begin
          state_d = S_DONE;
        end else begin
          links_d   = {child_entry[LINK1_LO +: NODE_BITS], child_entry[LINK0_LO +: NODE_BITS]};
          rd_addr_a = child_entry[LINK0_LO +: NODE_BITS];
          rd_addr_b = child_entry[LINK1_LO +: NODE_BITS];
          level_d   = level_q + LVL_W'(1);
          key_sh_d  = key_sh_q << 1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          xor_d       = acc_q[ResultW-1:0];
          status_d    = res_stat_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign root_valid_d = root_valid_q || (wr_en && wr_addr == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_free_q  <= FREE_W'(1);
      root_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      next_free_q  <= next_free_d;
      root_valid_q <= root_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    key_sh_q   <= key_sh_d;
    level_q    <= level_d;
    node_q     <= node_d;
    fresh_q    <= fresh_d;
    pass2_q    <= pass2_d;
    links_q    <= links_d;
    acc_q      <= acc_d;
    res_stat_q <= res_stat_d;
    a_zero_q   <= (rd_addr_a == '0);
    xor_q      <= xor_d;
    status_q   <= status_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign xor_result_o = xor_q;
  assign status_o     = status_q;

endmodule

/* design/btx_checker.sv */
// Port-level assertions for the binary trie xor query block and their bind.
module btx_checker
  import btx_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [CmdW-1:0]    command_i,
  input logic [KeyW-1:0]    key_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ResultW-1:0] xor_result_o,
  input logic [StatusW-1:0] status_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(xor_result_o) && $stable(status_o))
    else $error("result changed while stalled");

  // A result with a failure status carries a zero xor result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> xor_result_o == '0)
    else $error("nonzero xor result with a failure status");

  // After a command transfer the block is busy walking the trie.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new command taken while the previous one is in progress");

  // No result appears in the cycle right after a command transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind binary_trie_xor_query btx_checker u_btx_checker (.*);
